// ===== rtl/integer_to_word_tokens_core_defines.svh =====
// ----------------------------------------------------------------------------
// integer to word tokens: assertion macros
// shared property shapes for the checks at the end of the rtl modules
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_WORD_TOKENS_CORE_DEFINES_SVH
`define INTEGER_TO_WORD_TOKENS_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define ITTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never be seen outside reset
`define ITTW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/ittw_pkg.sv =====
// ----------------------------------------------------------------------------
// integer to word tokens: package
// widths, token codes and shared types
// ----------------------------------------------------------------------------
package ittw_pkg;

  localparam int VALUE_BITS = 31;
  // decimal digits of the largest value, floor(n * log10(2)) + 1
  localparam int DEC_DIGITS = (VALUE_BITS * 302) / 1000 + 1;
  localparam int GROUPS     = (DEC_DIGITS + 2) / 3;
  localparam int BCD_W      = GROUPS * 12;
  localparam int NDIG       = BCD_W / 4;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int GRP_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int S_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CODE_W     = 5;
  localparam int M_DATA_W   = 8;

  localparam logic [CODE_W-1:0] TOK_ZERO      = 5'd0;
  localparam logic [CODE_W-1:0] TOK_TEEN_BASE = 5'd10;
  localparam logic [CODE_W-1:0] TOK_TENS_BASE = 5'd18;
  localparam logic [CODE_W-1:0] TOK_HUNDRED   = 5'd28;

  typedef struct packed {
    logic busy;
    logic done;
  } b2d_stat_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_HUND,
    SQ_HWORD,
    SQ_TENS,
    SQ_UNITS,
    SQ_SCALE,
    SQ_FLUSH
  } seq_state_e;

endpackage

// ===== rtl/integer_to_word_tokens_core.sv =====
// order: the value passes through the converter, then the sequencer starts and walks the digits,
// and the first token leaves only once a second token is emitted or the run is flushed
// sequencer: four or five steps per thousand-group, the units step only after a tens word
// one value at a time: a new value is taken only when converter and sequencer are idle
// output stalls hold the sequencer and so delay the next value
// reset: rst_ni asynchronous active low, clears all control state, no clearing pass
// ----------------------------------------------------------------------------
// integer to word tokens: top level
// names a non-negative integer as a run of english word tokens
// ----------------------------------------------------------------------------
module integer_to_word_tokens_core
  import ittw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side: value [30:0], zero padded
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // master side: word_code [4:0], zero padded
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  // last_word
  output logic                m_axis_tlast_o
);

  b2d_stat_t         b2d_stat;
  logic [BCD_W-1:0]  bcd;
  logic              seq_idle;
  logic              in_xfer;
  logic [CODE_W-1:0] code;

  // one value in flight; a finished token may still wait at the output
  assign s_axis_tready_o = !b2d_stat.busy && !b2d_stat.done && seq_idle;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // decimal digits built one value bit per cycle
  ittw_b2d u_b2d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .value_i (s_axis_tdata_i[VALUE_BITS-1:0]),
    .stat_o  (b2d_stat),
    .bcd_o   (bcd)
  );

  // digits stay put in the converter while the sequencer walks them
  ittw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (b2d_stat.done),
    .bcd_i      (bcd),
    .idle_o     (seq_idle),
    .out_vld_o  (m_axis_tvalid_o),
    .out_rdy_i  (m_axis_tready_i),
    .out_code_o (code),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = M_DATA_W'(code);

endmodule

// ===== rtl/ittw_b2d.sv =====
// ----------------------------------------------------------------------------
// integer to word tokens: binary to decimal converter
// bit-serial shift-and-add-three, one input bit per cycle
// ----------------------------------------------------------------------------
module ittw_b2d
  import ittw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output b2d_stat_t             stat_o,
  output logic [BCD_W-1:0]      bcd_o
);

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, adj;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;

  // correct every digit that would overflow on the next doubling
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                  : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    val_d  = val_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = value_i;
      bcd_d  = '0;
      cnt_d  = CNT_W'(VALUE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[VALUE_BITS-2:0], 1'b0};
      bcd_d = {adj[BCD_W-2:0], val_q[VALUE_BITS-1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign bcd_o       = bcd_q;

endmodule

// ===== rtl/ittw_seq.sv =====
// ----------------------------------------------------------------------------
// integer to word tokens: token sequencer
// walks the thousand-groups and emits at most one word token per step
// ----------------------------------------------------------------------------
module ittw_seq
  import ittw_pkg::*;
`include "integer_to_word_tokens_core_defines.svh"
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [BCD_W-1:0]  bcd_i,
  output logic              idle_o,
  output logic              out_vld_o,
  input  logic              out_rdy_i,
  output logic [CODE_W-1:0] out_code_o,
  output logic              out_last_o
);

  seq_state_e        state_q, state_d;
  logic [GRP_W-1:0]  grp_q, grp_d, scl;
  logic [11:0]       grp_arr [GROUPS];
  logic [11:0]       cur;
  logic [3:0]        hun, ten, uni;
  logic              grp_nz, last_grp, can_push, emit;
  logic [CODE_W-1:0] tok;
  logic [CODE_W-1:0] pend_q;
  logic              pend_vld_q;
  logic              push_mid, push_fin;
  logic              out_vld_q, out_last_q;
  logic [CODE_W-1:0] out_code_q;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_arr[g] = bcd_i[g*12 +: 12];
    end
  end

  // group counter counts up, so the groups are walked from the most significant down
  assign scl      = GRP_W'(GROUPS - 1) - grp_q;
  assign cur      = grp_arr[scl];
  assign hun      = cur[11:8];
  assign ten      = cur[7:4];
  assign uni      = cur[3:0];
  assign grp_nz   = (cur != '0);
  assign last_grp = (grp_q == GRP_W'(GROUPS - 1));
  assign can_push = !out_vld_q || out_rdy_i;

  always_comb begin
    state_d = state_q;
    grp_d   = grp_q;
    emit    = 1'b0;
    tok     = TOK_ZERO;
    unique case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          state_d = SQ_HUND;
          grp_d   = '0;
        end
      end
      SQ_HUND: begin
        emit    = (hun != 4'd0);
        tok     = CODE_W'(hun);
        state_d = SQ_HWORD;
      end
      SQ_HWORD: begin
        emit    = (hun != 4'd0);
        tok     = TOK_HUNDRED;
        state_d = SQ_TENS;
      end
      SQ_TENS: begin
        state_d = SQ_SCALE;
        if (ten == 4'd1) begin
          emit = 1'b1;
          tok  = TOK_TEEN_BASE + CODE_W'(uni);
        end else if (ten != 4'd0) begin
          emit = 1'b1;
          tok  = TOK_TENS_BASE + CODE_W'(ten);
          if (uni != 4'd0) begin
            state_d = SQ_UNITS;
          end
        end else begin
          emit = (uni != 4'd0);
          tok  = CODE_W'(uni);
        end
      end
      SQ_UNITS: begin
        emit    = 1'b1;
        tok     = CODE_W'(uni);
        state_d = SQ_SCALE;
      end
      SQ_SCALE: begin
        // thousand, million, billion follow hundred in the code space
        emit = grp_nz && (scl != '0);
        tok  = TOK_HUNDRED + CODE_W'(scl);
        if (last_grp) begin
          state_d = SQ_FLUSH;
        end else begin
          state_d = SQ_HUND;
          grp_d   = grp_q + 1'b1;
        end
      end
      SQ_FLUSH: begin
        state_d = SQ_IDLE;
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
    if (state_q != SQ_IDLE && !can_push) begin
      state_d = state_q;
      grp_d   = grp_q;
      emit    = 1'b0;
    end
  end

  // one token held back so the final one can carry the last flag
  assign push_mid = emit && pend_vld_q;
  assign push_fin = (state_q == SQ_FLUSH) && can_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SQ_IDLE;
      grp_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      if (emit) begin
        pend_vld_q <= 1'b1;
      end else if (push_fin) begin
        pend_vld_q <= 1'b0;
      end
      if (push_mid || push_fin) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pend_q <= tok;
    end
    if (push_mid) begin
      out_code_q <= pend_q;
      out_last_q <= 1'b0;
    end else if (push_fin) begin
      out_code_q <= pend_vld_q ? pend_q : TOK_ZERO;
      out_last_q <= 1'b1;
    end
  end

  assign idle_o     = (state_q == SQ_IDLE);
  assign out_vld_o  = out_vld_q;
  assign out_code_o = out_code_q;
  assign out_last_o = out_last_q;

  `ITTW_ASSERT_IMP(a_no_overwrite, (push_mid || push_fin) && out_vld_q, out_rdy_i,
    "token register overwritten while held")
  `ITTW_ASSERT_IMP(a_pend_empty_idle, state_q == SQ_IDLE, !pend_vld_q,
    "held token left over after a run")
  `ITTW_ASSERT_NEVER(a_zero_alone, out_vld_q && !out_last_q && out_code_q == TOK_ZERO,
    "zero token inside a longer run")

endmodule
